// ===== rtl/lru_result_cache_assert.svh =====
// assertion helpers for the lru result cache
`ifndef LRU_RESULT_CACHE_ASSERT_SVH
`define LRU_RESULT_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define LRC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define LRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LRC_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define LRC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/lrc_pkg.sv =====
package lrc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int               CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
    } t_req_ctl;

endpackage

// ===== rtl/lrc_req_reg.sv =====
module lrc_req_reg #(
    parameter int KEY_BITS   = lrc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lrc_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_mode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output lrc_pkg::t_req_ctl     o_req,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);
    import lrc_pkg::*;

    t_req_ctl              r_req;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
        end else begin
            r_req.valid <= i_accept;
            if (i_accept) begin
                r_req.mode <= t_mode'(i_mode);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    assign o_req   = r_req;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

// ===== rtl/lrc_core.sv =====
module lrc_core #(
    parameter int ENTRIES    = lrc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lrc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lrc_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrc_pkg::t_req_ctl            i_req,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic [lrc_pkg::CAP_BITS-1:0] i_capacity,
    output logic                         o_hit,
    output logic [VALUE_BITS-1:0]        o_value
);
    import lrc_pkg::*;

    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CAPW = (CAP_BITS > CW) ? CAP_BITS : CW;

    logic [ENTRIES-1:0]                 r_valid, n_valid;
    logic [ENTRIES-1:0][RW-1:0]         r_rank, n_rank;
    logic [CW-1:0]                      r_count, n_count;
    logic [ENTRIES-1:0][KEY_BITS-1:0]   r_keys, n_keys;
    logic [ENTRIES-1:0][VALUE_BITS-1:0] r_vals, n_vals;

    logic [ENTRIES-1:0]    hit_vec;
    logic                  found;
    logic [RW-1:0]         found_rank;
    logic [VALUE_BITS-1:0] found_val;
    logic [ENTRIES-1:0]    evict_vec;
    logic [ENTRIES-1:0]    kept;
    logic [ENTRIES-1:0]    free_vec;
    logic [ENTRIES-1:0]    slot_oh;
    logic [CAPW-1:0]       cap_ext;
    logic [CAPW-1:0]       cap_eff;
    logic                  evict;
    logic [RW-1:0]         last_rank;

    // tag compare across all entries, keys are unique among valid entries
    always_comb begin
        found_rank = '0;
        found_val  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == i_key);
            if (hit_vec[i]) begin
                found_rank = found_rank | r_rank[i];
                found_val  = found_val | r_vals[i];
            end
        end
        found = |hit_vec;
    end

    // victim is the valid entry of rank count-1
    always_comb begin
        cap_ext   = CAPW'(i_capacity);
        cap_eff   = (cap_ext > CAPW'(ENTRIES)) ? CAPW'(ENTRIES) : cap_ext;
        evict     = CAPW'(r_count) >= cap_eff;
        last_rank = RW'(r_count - CW'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            evict_vec[i] = evict && r_valid[i] && (r_rank[i] == last_rank);
        end
        kept     = r_valid & ~evict_vec;
        free_vec = ~kept;
        slot_oh  = free_vec & (~free_vec + ENTRIES'(1));
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        n_keys  = r_keys;
        n_vals  = r_vals;
        o_hit   = 1'b0;
        o_value = '0;
        if (i_req.valid) begin
            unique case (i_req.mode)
                MODE_LOOKUP, MODE_INSERT: begin
                    if (found) begin
                        o_hit = 1'b1;
                        if (i_req.mode == MODE_LOOKUP) begin
                            o_value = found_val;
                        end
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] < found_rank)) begin
                                n_rank[i] = r_rank[i] + RW'(1);
                            end
                            if (hit_vec[i]) begin
                                n_rank[i] = '0;
                                if (i_req.mode == MODE_INSERT) begin
                                    n_vals[i] = i_value;
                                end
                            end
                        end
                    end else if (i_req.mode == MODE_INSERT &&
                                 !(evict && (r_count == '0))) begin
                        n_valid = kept | slot_oh;
                        if (!evict) begin
                            n_count = r_count + CW'(1);
                        end
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (kept[i]) begin
                                n_rank[i] = r_rank[i] + RW'(1);
                            end
                            if (slot_oh[i]) begin
                                n_rank[i] = '0;
                                n_keys[i] = i_key;
                                n_vals[i] = i_value;
                            end
                        end
                    end
                end
                MODE_CLEAR: begin
                    n_valid = '0;
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rank  <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_keys <= n_keys;
        r_vals <= n_vals;
    end

endmodule

// ===== rtl/lru_result_cache.sv =====
// fully associative lru cache of key tags and value handles
// request channel: drive start with i_mode, i_key and i_value_in; a transaction
//   is taken at a clock edge with start high and busy low. busy stays low, so a
//   new request may be issued in every cycle.
// modes: lookup, insert or update, clear all entries; other codes do nothing
//   but still return a result with hit and value clear.
// result channel: o_strobe is high for one cycle with o_hit and o_value_out;
//   the receiver cannot stall, so a result must be taken when shown.
// a request passes through the request register, then through the tag compare
//   and rank update into the result register. throughput is one request per
//   cycle; the next request sees the state left by the one before.
// capacity is set through i_cfg_we / i_cfg_wdata while no request is in flight;
//   values above the entry count saturate to it.
// reset (synchronous, active low) empties the cache, sets capacity to 16 and
//   drops any request in flight. no clearing pass is needed.
`include "lru_result_cache_assert.svh"

module lru_result_cache #(
    parameter int ENTRIES    = lrc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lrc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lrc_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value_in,
    input  logic                         i_cfg_we,
    input  logic [lrc_pkg::CAP_BITS-1:0] i_cfg_wdata,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic [VALUE_BITS-1:0]        o_value_out
);
    import lrc_pkg::*;

    logic                  accept;
    t_req_ctl              req;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic                  core_hit;
    logic [VALUE_BITS-1:0] core_value;

    logic [CAP_BITS-1:0]   r_capacity;
    logic                  r_strobe;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_value;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    lrc_req_reg #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_req_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_mode),
        .i_key    (i_key),
        .i_value  (i_value_in),
        .o_req    (req),
        .o_key    (req_key),
        .o_value  (req_value)
    );

    lrc_core #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_key      (req_key),
        .i_value    (req_value),
        .i_capacity (r_capacity),
        .o_hit      (core_hit),
        .o_value    (core_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= core_hit;
        r_value <= core_value;
    end

    assign o_strobe    = r_strobe;
    assign o_hit       = r_strobe && r_hit;
    assign o_value_out = r_strobe ? r_value : '0;

    `LRC_ASSERT_ALWAYS(a_strobe_follows_req, i_clk,
        $past(i_rst_n) |-> (o_strobe == $past(req.valid)),
        "result strobe without a registered request")
    `LRC_ASSERT_RST(a_value_needs_lookup_hit, i_clk, i_rst_n,
        (o_value_out != '0) |-> (o_hit && $past(req.mode == MODE_LOOKUP)),
        "nonzero value without a lookup hit")
    `LRC_ASSERT_ALWAYS(a_hit_needs_strobe, i_clk, o_hit |-> o_strobe,
        "hit shown outside a result")

endmodule

// ===== sim/tb_lru_result_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_result_cache;
    import lrc_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef struct {
        bit                      is_cfg;
        logic [CAP_BITS-1:0]     cap;
        logic [1:0]              mode;
        logic [KEY_BITS_DEF-1:0] key;
        logic [VALUE_BITS_DEF-1:0] value;
    } t_job;

    typedef struct {
        logic                      hit;
        logic [VALUE_BITS_DEF-1:0] value;
    } t_reply;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  i_mode = MODE_LOOKUP;
    logic [KEY_BITS_DEF-1:0]     i_key = '0;
    logic [VALUE_BITS_DEF-1:0]   i_value_in = '0;
    logic                        i_cfg_we = 1'b0;
    logic [CAP_BITS-1:0]         i_cfg_wdata = '0;
    logic                        o_strobe;
    logic                        o_hit;
    logic [VALUE_BITS_DEF-1:0]   o_value_out;

    // shadow copy of the cache contents
    logic [KEY_BITS_DEF-1:0]     shadow_keys [SLOTS];
    logic [VALUE_BITS_DEF-1:0]   shadow_vals [SLOTS];
    bit                          shadow_valid [SLOTS];
    int                          shadow_rank [SLOTS];
    int                          shadow_cap = CAP_RESET;

    t_job   job_q[$];
    t_reply awaited_replies[$];
    int     sent_cnt = 0;
    int     taken_cnt = 0;
    int     err_cnt = 0;

    lru_result_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_key       (i_key),
        .i_value_in  (i_value_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_hit       (o_hit),
        .o_value_out (o_value_out)
    );

    always #5 i_clk = ~i_clk;

    // move entry e to the front, entries newer than it age by one
    function automatic void promote(input int e);
        int r;
        r = shadow_rank[e];
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
        end
        shadow_rank[e] = 0;
    endfunction

    function automatic t_reply lru_access(input logic [1:0] op,
                                          input logic [KEY_BITS_DEF-1:0] key,
                                          input logic [VALUE_BITS_DEF-1:0] val);
        t_reply r;
        int     found;
        int     cnt;
        int     cap_eff;
        int     slot;
        bit     keep;
        r.hit = 1'b0;
        r.value = '0;
        found = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_keys[i] == key) found = i;
        end
        if (op == MODE_LOOKUP) begin
            if (found >= 0) begin
                promote(found);
                r.hit = 1'b1;
                r.value = shadow_vals[found];
            end
        end else if (op == MODE_INSERT) begin
            if (found >= 0) begin
                shadow_vals[found] = val;
                promote(found);
                r.hit = 1'b1;
            end else begin
                cap_eff = (shadow_cap > SLOTS) ? SLOTS : shadow_cap;
                cnt = 0;
                for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) cnt++;
                keep = 1'b1;
                if (cnt + 1 > cap_eff) begin
                    if (cnt == 0) begin
                        keep = 1'b0;
                    end else begin
                        // drop only the oldest one, even if still over capacity
                        for (int i = 0; i < SLOTS; i++) begin
                            if (shadow_valid[i] && shadow_rank[i] == cnt - 1) begin
                                shadow_valid[i] = 1'b0;
                                shadow_rank[i] = 0;
                                break;
                            end
                        end
                    end
                end
                if (keep) begin
                    slot = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot < 0 && !shadow_valid[i]) slot = i;
                    end
                    if (slot >= 0) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (shadow_valid[i]) shadow_rank[i]++;
                        end
                        shadow_keys[slot] = key;
                        shadow_vals[slot] = val;
                        shadow_valid[slot] = 1'b1;
                        shadow_rank[slot] = 0;
                    end
                end
            end
        end else if (op == MODE_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i] = 0;
            end
        end
        return r;
    endfunction

    function automatic t_job req(input logic [1:0] op, input logic [KEY_BITS_DEF-1:0] key,
                                 input logic [VALUE_BITS_DEF-1:0] val);
        t_job j;
        j.is_cfg = 1'b0;
        j.cap = '0;
        j.mode = op;
        j.key = key;
        j.value = val;
        return j;
    endfunction

    function automatic t_job cfg(input logic [CAP_BITS-1:0] c);
        t_job j;
        j = req(MODE_LOOKUP, '0, '0);
        j.is_cfg = 1'b1;
        j.cap = c;
        return j;
    endfunction

    function automatic void add_job(input t_job j);
        job_q.insert(job_q.size(), j);
    endfunction

    // driver
    always @(negedge i_clk) begin : drive
        logic nxt_start;
        logic nxt_we;
        bit   idle_on;
        nxt_start = 1'b0;
        nxt_we = 1'b0;
        // no idling through a long middle stretch
        idle_on = !(taken_cnt >= 500 && taken_cnt < 800);
        if (i_rst_n) begin
            if (start && sent_cnt != taken_cnt) begin
                nxt_start = 1'b1;
            end else if (job_q.size() > 0) begin
                if (job_q[0].is_cfg) begin
                    if (awaited_replies.size() == 0 && !start) begin
                        nxt_we = 1'b1;
                        i_cfg_wdata <= job_q[0].cap;
                        void'(job_q.pop_front());
                    end
                end else if (!(idle_on && $urandom_range(0, 99) < 23)) begin
                    nxt_start = 1'b1;
                    i_mode <= job_q[0].mode;
                    i_key <= job_q[0].key;
                    i_value_in <= job_q[0].value;
                    void'(job_q.pop_front());
                    sent_cnt++;
                end
            end
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    // monitor: check results, then predict for the transaction taken here
    always @(posedge i_clk) begin : watch
        t_reply exp_r;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (awaited_replies.size() == 0) begin
                    $error("result with no transaction outstanding: hit %0b value_out %h",
                           o_hit, o_value_out);
                    err_cnt++;
                end else begin
                    exp_r = awaited_replies.pop_front();
                    if (o_hit !== exp_r.hit) begin
                        $error("hit: expected %0b, got %0b", exp_r.hit, o_hit);
                        err_cnt++;
                    end
                    if (o_value_out !== exp_r.value) begin
                        $error("value_out: expected %h, got %h", exp_r.value, o_value_out);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we) shadow_cap = i_cfg_wdata;
            if (start && !busy) begin
                awaited_replies.insert(awaited_replies.size(),
                                       lru_access(i_mode, i_key, i_value_in));
                taken_cnt++;
            end
        end
    end

    initial begin : stimulus
        logic [KEY_BITS_DEF-1:0] ones;
        logic [KEY_BITS_DEF-1:0] pool [$];
        logic [CAP_BITS-1:0]     caps [10];
        logic [1:0]              op;
        int                      pick;

        for (int i = 0; i < SLOTS; i++) begin
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i] = 0;
        end
        ones = '1;

        // directed part, capacity at its reset value
        add_job(req(MODE_LOOKUP, '0, '1));
        add_job(req(MODE_INSERT, '0, '0));
        add_job(req(MODE_INSERT, ones, '1));
        add_job(req(MODE_LOOKUP, ones, '0));
        add_job(req(MODE_LOOKUP, '0, '1));
        add_job(req(MODE_INSERT, ones, 32'ha5a5_a5a5));
        add_job(req(MODE_LOOKUP, ones, '0));
        add_job(req(MODE_NOP, '0, '1));
        add_job(req(MODE_LOOKUP, '0, '0));
        add_job(req(MODE_CLEAR, ones, '1));
        add_job(req(MODE_LOOKUP, ones, '0));
        // zero capacity keeps nothing
        add_job(cfg(5'd0));
        add_job(req(MODE_INSERT, 64'h123, 32'h5555_aaaa));
        add_job(req(MODE_LOOKUP, 64'h123, '0));
        // capacity of one: second insert pushes the first out
        add_job(cfg(5'd1));
        add_job(req(MODE_INSERT, 64'h5, 32'h1));
        add_job(req(MODE_INSERT, 64'h6, 32'h2));
        add_job(req(MODE_LOOKUP, 64'h5, '0));
        add_job(req(MODE_LOOKUP, 64'h6, '0));

        // random phases; large then small capacities leave the cache over-full
        caps = '{5'd31, 5'd16, 5'd2, 5'd0, 5'd12, 5'd17, 5'd1, 5'd16, 5'd3, 5'd8};
        for (int ph = 0; ph < 10; ph++) begin
            add_job(cfg(caps[ph]));
            pool.delete();
            repeat ($urandom_range(2, 24)) pool.insert(pool.size(), {$urandom, $urandom});
            repeat (133) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) op = MODE_LOOKUP;
                else if (pick < 94) op = MODE_INSERT;
                else if (pick < 97) op = MODE_CLEAR;
                else op = MODE_NOP;
                if ($urandom_range(0, 9) == 0)
                    add_job(req(op, {$urandom, $urandom}, $urandom));
                else
                    add_job(req(op, pool[$urandom_range(0, pool.size() - 1)],
                                $urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() > 0 || sent_cnt != taken_cnt || awaited_replies.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
